// ===== src/bnms_pkg.sv =====
package bnms_pkg;

  // Field widths of one box.
  localparam int COORD_BITS = 14;
  localparam int SIZE_BITS  = COORD_BITS - 1;
  localparam int SCORE_BITS = 16;
  localparam int THR_BITS   = 17;
  localparam int TAG_BITS   = 6;
  localparam int AREA_BITS  = 2 * SIZE_BITS;
  localparam int DENOM_BITS = AREA_BITS + 1;
  localparam int PROD_BITS  = DENOM_BITS + THR_BITS;

  // Configuration register indexes.
  localparam logic [0:0] REG_THRESHOLD = 1'b0;
  localparam logic [0:0] REG_MODE      = 1'b1;
  localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(32768);

  // One stored box as it travels along the chain.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] left;
    logic signed [COORD_BITS-1:0] top;
    logic [SIZE_BITS-1:0]         width;
    logic [SIZE_BITS-1:0]         height;
    logic signed [SCORE_BITS-1:0] score;
    logic                         alive;
    logic [TAG_BITS-1:0]          tag;
  } box_t;

  // What every cell does in a cycle.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP,
    OP_ROTATE
  } cell_op_t;

  // Broadcast control shared by all cells.
  typedef struct packed {
    cell_op_t            op;
    logic                kill;
    logic [TAG_BITS-1:0] kill_tag;
    box_t                new_box;
  } cell_ctrl_t;

endpackage

// ===== src/bnms_cell.sv =====
module bnms_cell (
  input  logic                 clk,
  input  bnms_pkg::cell_ctrl_t ctrl,
  input  bnms_pkg::box_t       left_box,
  input  bnms_pkg::box_t       right_box,
  input  bnms_pkg::box_t       head_box,
  input  logic                 ge_left,
  input  logic                 is_tail,
  input  logic                 in_use,
  output bnms_pkg::box_t       box,
  output logic                 ge
);

  bnms_pkg::box_t src;
  bnms_pkg::box_t box_next;

  // A held box ranks ahead of the new one when its score is not lower.
  assign ge = in_use && (box.score >= ctrl.new_box.score);

  // Pick where this cell's next box comes from.
  always_comb begin
    unique case (ctrl.op)
      bnms_pkg::OP_HOLD:   src = box;
      bnms_pkg::OP_INSERT: begin
        if (ge) begin
          src = box;
        end else if (ge_left) begin
          src = ctrl.new_box;
        end else begin
          src = left_box;
        end
      end
      bnms_pkg::OP_POP:    src = right_box;
      bnms_pkg::OP_ROTATE: src = is_tail ? head_box : right_box;
      default:             src = box;
    endcase
  end

  // Apply a suppression result to the box that lands here.
  always_comb begin
    box_next       = src;
    box_next.alive = src.alive & ~(ctrl.kill && (src.tag == ctrl.kill_tag));
  end

  always_ff @(posedge clk) begin
    box <= box_next;
  end

endmodule

// ===== src/bnms_overlap.sv =====
module bnms_overlap (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              issue,
  input  bnms_pkg::box_t                    major,
  input  bnms_pkg::box_t                    minor,
  input  logic [bnms_pkg::THR_BITS-1:0]     thr,
  input  logic                              mode,
  output logic                              kill,
  output logic [bnms_pkg::TAG_BITS-1:0]     kill_tag,
  output logic                              active
);

  localparam int CB = bnms_pkg::COORD_BITS;
  localparam int SB = bnms_pkg::SIZE_BITS;
  localparam int AB = bnms_pkg::AREA_BITS;
  localparam int DB = bnms_pkg::DENOM_BITS;
  localparam int PB = bnms_pkg::PROD_BITS;
  localparam int TB = bnms_pkg::TAG_BITS;

  logic [CB:0]   ra, rb, ba, bb;
  logic [CB-1:0] x1, y1;
  logic [CB:0]   x2, y2;
  logic [CB+1:0] dx, dy;
  logic [SB-1:0] iw, ih;

  logic          v1, v2, v3, v4;
  logic [TB-1:0] t1, t2, t3, t4;
  logic [SB-1:0] iw1, ih1;
  logic [AB-1:0] amaj1, amin1, amaj2, amin2, inter2, inter3, inter4;
  logic [DB-1:0] denom3;
  logic [PB-1:0] prod4;
  logic [PB-1:0] lhs;

  // Intersection edges of the two boxes.
  always_comb begin
    ra = {major.left[CB-1], major.left} + {2'b00, major.width};
    rb = {minor.left[CB-1], minor.left} + {2'b00, minor.width};
    ba = {major.top[CB-1], major.top} + {2'b00, major.height};
    bb = {minor.top[CB-1], minor.top} + {2'b00, minor.height};
    x1 = (major.left > minor.left) ? major.left : minor.left;
    y1 = (major.top > minor.top) ? major.top : minor.top;
    x2 = ($signed(ra) < $signed(rb)) ? ra : rb;
    y2 = ($signed(ba) < $signed(bb)) ? ba : bb;
    dx = {x2[CB], x2} - {{2{x1[CB-1]}}, x1};
    dy = {y2[CB], y2} - {{2{y1[CB-1]}}, y1};
    iw = (!dx[CB+1] && (dx != '0)) ? dx[SB-1:0] : '0;
    ih = (!dy[CB+1] && (dy != '0)) ? dy[SB-1:0] : '0;
  end

  // Valid bits of the compare pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Areas, intersection, denominator and threshold product, one per stage.
  always_ff @(posedge clk) begin
    t1     <= minor.tag;
    iw1    <= iw;
    ih1    <= ih;
    amaj1  <= AB'(major.width) * AB'(major.height);
    amin1  <= AB'(minor.width) * AB'(minor.height);
    t2     <= t1;
    inter2 <= AB'(iw1) * AB'(ih1);
    amaj2  <= amaj1;
    amin2  <= amin1;
    t3     <= t2;
    inter3 <= inter2;
    denom3 <= mode ? {1'b0, amin2}
                   : ({1'b0, amaj2} + {1'b0, amin2} - {1'b0, inter2});
    t4     <= t3;
    inter4 <= inter3;
    prod4  <= PB'(thr) * PB'(denom3);
  end

  // The ratio test without division: inter * 65536 > thr * denom.
  assign lhs      = {2'b00, inter4, 16'b0};
  assign kill     = v4 && (lhs > prod4);
  assign kill_tag = t4;
  assign active   = v1 | v2 | v3 | v4;

endmodule

// ===== src/box_non_maximum_suppression.sv =====
// Boxes load one per cycle; start is taken whenever busy is low.
// After the final box, each popped surviving box sweeps the r boxes behind it
// through a four-stage overlap unit, while a suppressed one just pops.
// Results come one per strobe.
// The receiver cannot stall; each result shows for exactly one cycle.
// Synchronous reset empties the set and loads the register reset values.
module box_non_maximum_suppression #(
  parameter int MAX_BOXES = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [bnms_pkg::COORD_BITS-1:0] box_left,
  input  logic signed [bnms_pkg::COORD_BITS-1:0] box_top,
  input  logic [bnms_pkg::SIZE_BITS-1:0]         box_width,
  input  logic [bnms_pkg::SIZE_BITS-1:0]         box_height,
  input  logic signed [bnms_pkg::SCORE_BITS-1:0] score,
  input  logic                                  final_box,
  output logic                                  strobe,
  output logic signed [bnms_pkg::COORD_BITS-1:0] kept_left,
  output logic signed [bnms_pkg::COORD_BITS-1:0] kept_top,
  output logic [bnms_pkg::SIZE_BITS-1:0]         kept_width,
  output logic [bnms_pkg::SIZE_BITS-1:0]         kept_height,
  output logic signed [bnms_pkg::SCORE_BITS-1:0] kept_score,
  output logic                                  last_kept,
  output logic                                  overflowed,
  input  logic                                  write_enable,
  input  logic [0:0]                            write_index,
  input  logic [bnms_pkg::THR_BITS-1:0]          write_data
);

  localparam int CW = $clog2(MAX_BOXES + 1);

  typedef enum logic [1:0] {S_LOAD, S_POP, S_SWEEP, S_DRAIN} state_t;

  state_t                        state;
  logic [CW-1:0]                 count, remain, sweep;
  logic                          ovf;
  logic                          pend_valid;
  bnms_pkg::box_t                pend, major;
  logic [bnms_pkg::THR_BITS-1:0] thr;
  logic                          mode;

  bnms_pkg::cell_ctrl_t          ctrl;
  bnms_pkg::box_t                cells [MAX_BOXES];
  logic [MAX_BOXES-1:0]          ge;
  logic                          issue, kill, pipe_active;
  logic [bnms_pkg::TAG_BITS-1:0] kill_tag;
  logic                          room;

  assign busy = (state != S_LOAD);
  assign room = (count < CW'(MAX_BOXES));

  // Control broadcast to the chain.
  always_comb begin
    ctrl.op               = bnms_pkg::OP_HOLD;
    ctrl.kill             = kill;
    ctrl.kill_tag         = kill_tag;
    ctrl.new_box.left     = box_left;
    ctrl.new_box.top      = box_top;
    ctrl.new_box.width    = box_width;
    ctrl.new_box.height   = box_height;
    ctrl.new_box.score    = score;
    ctrl.new_box.alive    = 1'b1;
    ctrl.new_box.tag      = bnms_pkg::TAG_BITS'(count);
    issue                 = 1'b0;
    unique case (state)
      S_LOAD: begin
        if (start && room) ctrl.op = bnms_pkg::OP_INSERT;
      end
      S_POP: begin
        if (remain != '0) ctrl.op = bnms_pkg::OP_POP;
      end
      S_SWEEP: begin
        ctrl.op = bnms_pkg::OP_ROTATE;
        issue   = cells[0].alive;
      end
      S_DRAIN: ctrl.op = bnms_pkg::OP_HOLD;
      default: ctrl.op = bnms_pkg::OP_HOLD;
    endcase
  end

  // The sorted chain of boxes, highest score in cell zero.
  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    bnms_pkg::box_t left_box, right_box;
    logic           ge_left;
    if (i == 0) begin : g_first
      assign left_box = cells[0];
      assign ge_left  = 1'b1;
    end else begin : g_inner
      assign left_box = cells[i-1];
      assign ge_left  = ge[i-1];
    end
    if (i == MAX_BOXES - 1) begin : g_last
      assign right_box = cells[i];
    end else begin : g_more
      assign right_box = cells[i+1];
    end
    bnms_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .left_box  (left_box),
      .right_box (right_box),
      .head_box  (cells[0]),
      .ge_left   (ge_left),
      .is_tail   (CW'(i) == (remain - CW'(1))),
      .in_use    (CW'(i) < count),
      .box       (cells[i]),
      .ge        (ge[i])
    );
  end

  // Shared overlap test of the current leader against each later box.
  bnms_overlap u_overlap (
    .clk      (clk),
    .rst      (rst),
    .issue    (issue),
    .major    (major),
    .minor    (cells[0]),
    .thr      (thr),
    .mode     (mode),
    .kill     (kill),
    .kill_tag (kill_tag),
    .active   (pipe_active)
  );

  // Sequencer, configuration registers and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      count      <= '0;
      remain     <= '0;
      sweep      <= '0;
      ovf        <= 1'b0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
      thr        <= bnms_pkg::THR_RESET;
      mode       <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (write_enable) begin
        unique case (write_index)
          bnms_pkg::REG_THRESHOLD: thr  <= write_data;
          bnms_pkg::REG_MODE:      mode <= write_data[0];
          default:                 thr  <= thr;
        endcase
      end
      unique case (state)
        S_LOAD: begin
          if (start) begin
            if (room) begin
              count <= count + CW'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (final_box) begin
              state  <= S_POP;
              remain <= room ? count + CW'(1) : count;
            end
          end
        end
        S_POP: begin
          if (remain == '0) begin
            // Chain is empty: the held survivor is the last one.
            strobe      <= 1'b1;
            kept_left   <= pend.left;
            kept_top    <= pend.top;
            kept_width  <= pend.width;
            kept_height <= pend.height;
            kept_score  <= pend.score;
            last_kept   <= 1'b1;
            overflowed  <= ovf;
            pend_valid  <= 1'b0;
            count       <= '0;
            ovf         <= 1'b0;
            state       <= S_LOAD;
          end else begin
            remain <= remain - CW'(1);
            if (cells[0].alive) begin
              if (pend_valid) begin
                strobe      <= 1'b1;
                kept_left   <= pend.left;
                kept_top    <= pend.top;
                kept_width  <= pend.width;
                kept_height <= pend.height;
                kept_score  <= pend.score;
                last_kept   <= 1'b0;
                overflowed  <= ovf;
              end
              pend       <= cells[0];
              pend_valid <= 1'b1;
              major      <= cells[0];
              sweep      <= remain - CW'(1);
              if (remain != CW'(1)) state <= S_SWEEP;
            end
          end
        end
        S_SWEEP: begin
          sweep <= sweep - CW'(1);
          if (sweep == CW'(1)) state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!pipe_active) state <= S_POP;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

// ===== src/bnms_checker.sv =====
module bnms_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic final_box,
  input logic busy,
  input logic strobe,
  input logic last_kept
);

  // A result only follows a cycle in which the block was working.
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy)) else $error("result without a busy cycle");

  // Accepting a new transaction is never followed at once by a result.
  a_accept_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !strobe) else $error("result right after accept");

  // The last result of a set closes the set.
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (strobe && last_kept) |=> !strobe) else $error("result after last");

  // A final box starts suppression.
  a_final_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && final_box) |=> busy) else $error("final box not taken");

  // Reset leaves the block idle and silent.
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> (!busy && !strobe)) else $error("not idle after reset");

endmodule

bind box_non_maximum_suppression bnms_checker u_bnms_checker (.*);
